/* design/mqrb_pkg.sv */
package mqrb_pkg;

  // Default sizing of the pool
  localparam int NUM_QUEUES_DEF     = 8;
  localparam int MAX_DEPTH_DEF      = 16;
  localparam int MAX_ITEM_BYTES_DEF = 8;

  // Fixed field widths
  localparam int MODE_W       = 2;
  localparam int QID_W        = 3;
  localparam int DATA_W       = 64;
  localparam int REQ_W        = 8;
  localparam int STATUS_W     = 3;
  localparam int HANDLE_W     = 3;
  localparam int ITEM_BYTES_W = 4;
  localparam int ADDR_SLOTS   = 8;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEND   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RECV   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE   = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NOSLOT = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic fetch;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rx_hit;
  } dp_status_t;

  // Keep the low nbytes bytes of a 64-bit word
  function automatic logic [DATA_W-1:0] byte_mask(logic [ITEM_BYTES_W-1:0] nbytes);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      m[8*b +: 8] = (ITEM_BYTES_W'(b) < nbytes) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

/* design/mqrb_ctrl.sv */
module mqrb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  mqrb_pkg::dp_status_t   dp_status,
  output mqrb_pkg::ctrl_cmd_t    cmd,
  output logic                   busy
);
  import mqrb_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = dp_status.rx_hit ? ST_FETCH : ST_IDLE;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/mqrb_datapath.sv */
module mqrb_datapath #(
  parameter int NUM_QUEUES     = mqrb_pkg::NUM_QUEUES_DEF,
  parameter int MAX_DEPTH      = mqrb_pkg::MAX_DEPTH_DEF,
  parameter int MAX_ITEM_BYTES = mqrb_pkg::MAX_ITEM_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mqrb_pkg::ctrl_cmd_t                 cmd,
  output mqrb_pkg::dp_status_t                dp_status,
  input  logic [mqrb_pkg::MODE_W-1:0]         in_mode,
  input  logic [mqrb_pkg::QID_W-1:0]          in_queue_id,
  input  logic [mqrb_pkg::DATA_W-1:0]         in_item_data,
  input  logic [mqrb_pkg::REQ_W-1:0]          in_req_depth,
  input  logic [mqrb_pkg::REQ_W-1:0]          in_req_item_bytes,
  output logic                                out_valid,
  output logic                                out_ok,
  output logic [mqrb_pkg::STATUS_W-1:0]       out_status,
  output logic [mqrb_pkg::HANDLE_W-1:0]       out_handle,
  output logic [mqrb_pkg::DATA_W-1:0]         out_item_out
);
  import mqrb_pkg::*;

  // Only the first eight slots can be addressed by a queue id
  localparam int SLOTS     = (NUM_QUEUES < ADDR_SLOTS) ? NUM_QUEUES : ADDR_SLOTS;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CLAIM_W   = $clog2(NUM_QUEUES + 1);
  localparam int PTR_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
  localparam int MEM_DEPTH = SLOTS * MAX_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Latched command
  logic [MODE_W-1:0] mode_r;
  logic [QID_W-1:0]  qid_r;
  logic [DATA_W-1:0] data_r;
  logic [REQ_W-1:0]  depth_r;
  logic [REQ_W-1:0]  isz_r;

  // Slot table; slots are claimed in order and never freed
  logic [CLAIM_W-1:0]      claimed_r;
  logic [CNT_W-1:0]        cap_r    [SLOTS];
  logic [ITEM_BYTES_W-1:0] ibytes_r [SLOTS];
  logic [PTR_W-1:0]        rdp_r    [SLOTS];
  logic [PTR_W-1:0]        wrp_r    [SLOTS];
  logic [CNT_W-1:0]        fill_r   [SLOTS];

  logic [DATA_W-1:0] mem [MEM_DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  logic                  valid_r;
  logic                  ok_r;
  logic [STATUS_W-1:0]   status_r;
  logic [HANDLE_W-1:0]   handle_r;
  logic [DATA_W-1:0]     item_r;

  logic [SLOT_W-1:0]     q_idx;
  logic [SLOT_W-1:0]     c_idx;
  logic                  q_in_use;
  logic                  create_bad;
  logic                  pool_full;
  logic                  claim_has_meta;
  logic                  do_create;
  logic                  do_send;
  logic                  do_recv;
  logic                  res_ok;
  logic [STATUS_W-1:0]   res_status;
  logic [PTR_W-1:0]      wrp_adv;
  logic [PTR_W-1:0]      rdp_adv;
  logic [CNT_W-1:0]      wr_inc;
  logic [CNT_W-1:0]      rd_inc;
  logic [ADDR_W-1:0]     mem_addr;
  logic [DATA_W-1:0]     wr_mask;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      qid_r   <= in_queue_id;
      data_r  <= in_item_data;
      depth_r <= in_req_depth;
      isz_r   <= in_req_item_bytes;
    end
  end

  assign q_idx          = qid_r[SLOT_W-1:0];
  assign c_idx          = SLOT_W'(claimed_r);
  assign q_in_use       = 32'(qid_r) < 32'(claimed_r);
  assign pool_full      = 32'(claimed_r) >= 32'(NUM_QUEUES);
  assign claim_has_meta = 32'(claimed_r) < 32'(SLOTS);
  assign create_bad     = (depth_r == '0) || (isz_r == '0) ||
                          (32'(depth_r) > 32'(MAX_DEPTH)) ||
                          (32'(isz_r) > 32'(MAX_ITEM_BYTES));

  // Pointer advance with wrap at the slot's capacity
  assign wr_inc  = CNT_W'(wrp_r[q_idx]) + CNT_W'(1);
  assign rd_inc  = CNT_W'(rdp_r[q_idx]) + CNT_W'(1);
  assign wrp_adv = (wr_inc >= cap_r[q_idx]) ? '0 : PTR_W'(wr_inc);
  assign rdp_adv = (rd_inc >= cap_r[q_idx]) ? '0 : PTR_W'(rd_inc);

  assign mem_addr = ADDR_W'(q_idx) * ADDR_W'(MAX_DEPTH) +
                    ADDR_W'((mode_r == MODE_SEND) ? wrp_r[q_idx] : rdp_r[q_idx]);
  assign wr_mask  = byte_mask(ibytes_r[q_idx]);

  always_comb begin
    do_create  = 1'b0;
    do_send    = 1'b0;
    do_recv    = 1'b0;
    res_ok     = 1'b0;
    res_status = STAT_BAD;
    unique case (mode_r)
      MODE_CREATE: begin
        if (create_bad) begin
          res_status = STAT_BAD;
        end else if (pool_full) begin
          res_status = STAT_NOSLOT;
        end else begin
          do_create  = 1'b1;
          res_ok     = 1'b1;
          res_status = STAT_DONE;
        end
      end
      MODE_SEND: begin
        if (!q_in_use) begin
          res_status = STAT_BAD;
        end else if (fill_r[q_idx] >= cap_r[q_idx]) begin
          res_status = STAT_FULL;
        end else begin
          do_send    = 1'b1;
          res_ok     = 1'b1;
          res_status = STAT_DONE;
        end
      end
      MODE_RECV: begin
        if (!q_in_use) begin
          res_status = STAT_BAD;
        end else if (fill_r[q_idx] == '0) begin
          res_status = STAT_EMPTY;
        end else begin
          do_recv    = 1'b1;
          res_ok     = 1'b1;
          res_status = STAT_DONE;
        end
      end
      default: begin
        res_status = STAT_BAD;
      end
    endcase
  end

  assign dp_status.rx_hit = do_recv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      claimed_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        cap_r[i]    <= '0;
        ibytes_r[i] <= '0;
        rdp_r[i]    <= '0;
        wrp_r[i]    <= '0;
        fill_r[i]   <= '0;
      end
    end else if (cmd.exec) begin
      if (do_create) begin
        claimed_r <= claimed_r + CLAIM_W'(1);
        if (claim_has_meta) begin
          cap_r[c_idx]    <= CNT_W'(depth_r);
          ibytes_r[c_idx] <= ITEM_BYTES_W'(isz_r);
          rdp_r[c_idx]    <= '0;
          wrp_r[c_idx]    <= '0;
          fill_r[c_idx]   <= '0;
        end
      end
      if (do_send) begin
        wrp_r[q_idx]  <= wrp_adv;
        fill_r[q_idx] <= fill_r[q_idx] + CNT_W'(1);
      end
      if (do_recv) begin
        rdp_r[q_idx]  <= rdp_adv;
        fill_r[q_idx] <= fill_r[q_idx] - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && do_send) begin
      mem[mem_addr] <= data_r & wr_mask;
    end
    rd_data_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= (cmd.exec && !do_recv) || cmd.fetch;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_r     <= res_ok;
      status_r <= res_status;
      handle_r <= do_create ? HANDLE_W'(claimed_r) : '0;
      item_r   <= '0;
    end else if (cmd.fetch) begin
      item_r   <= rd_data_r & wr_mask;
    end
  end

  assign out_valid    = valid_r;
  assign out_ok       = ok_r;
  assign out_status   = status_r;
  assign out_handle   = handle_r;
  assign out_item_out = item_r;

endmodule

/* design/multi_queue_ring_buffer_pool_unit.sv */
// A create, a send or a failed receive strobes its result after the execute state; a
// successful receive adds a fetch state after it, for the entry store read.
// A new start is taken only once the last transfer is through; busy falls in the
// cycle the result is shown, so the next start can be taken alongside the strobe.
// Reset (synchronous, rst_n low) empties the slot table and the controller; the entry
// store keeps its contents. The receiver cannot stall: out_valid lasts one cycle.
module multi_queue_ring_buffer_pool_unit #(
  parameter int NUM_QUEUES     = mqrb_pkg::NUM_QUEUES_DEF,
  parameter int MAX_DEPTH      = mqrb_pkg::MAX_DEPTH_DEF,
  parameter int MAX_ITEM_BYTES = mqrb_pkg::MAX_ITEM_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [mqrb_pkg::MODE_W-1:0]    in_mode,
  input  logic [mqrb_pkg::QID_W-1:0]     in_queue_id,
  input  logic [mqrb_pkg::DATA_W-1:0]    in_item_data,
  input  logic [mqrb_pkg::REQ_W-1:0]     in_req_depth,
  input  logic [mqrb_pkg::REQ_W-1:0]     in_req_item_bytes,
  output logic                           out_valid,
  output logic                           out_ok,
  output logic [mqrb_pkg::STATUS_W-1:0]  out_status,
  output logic [mqrb_pkg::HANDLE_W-1:0]  out_handle,
  output logic [mqrb_pkg::DATA_W-1:0]    out_item_out
);
  import mqrb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // Controller: sequence load, execute and (for a receive hit) the store fetch
  mqrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .dp_status (dp_status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Datapath: slot table, entry store and result registers
  mqrb_datapath #(
    .NUM_QUEUES     (NUM_QUEUES),
    .MAX_DEPTH      (MAX_DEPTH),
    .MAX_ITEM_BYTES (MAX_ITEM_BYTES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .dp_status         (dp_status),
    .in_mode           (in_mode),
    .in_queue_id       (in_queue_id),
    .in_item_data      (in_item_data),
    .in_req_depth      (in_req_depth),
    .in_req_item_bytes (in_req_item_bytes),
    .out_valid         (out_valid),
    .out_ok            (out_ok),
    .out_status        (out_status),
    .out_handle        (out_handle),
    .out_item_out      (out_item_out)
  );

  // An accepted transfer keeps the block busy for its execute cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after accepting a transfer");

  // Each result strobes for a single cycle
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // Success and a done status go together
  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ok == (out_status == STAT_DONE)))
    else $error("ok flag disagrees with status");

  // A failed operation returns no handle and no item
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> (out_handle == '0) && (out_item_out == '0))
    else $error("failed operation returned a handle or an item");

endmodule
